// ===== rtl/particle_pool_integrator_core_macros.svh =====
// assertion macros for the particle pool integrator
`ifndef PARTICLE_POOL_INTEGRATOR_CORE_MACROS_SVH
`define PARTICLE_POOL_INTEGRATOR_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/ppi_pkg.sv =====
package ppi_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int LIVE_W         = 7;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // result kinds
    localparam logic [1:0] KIND_EMIT = 2'd0;
    localparam logic [1:0] KIND_PART = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_GRAVITY = 3'd0;
    localparam logic [2:0] CFG_DAMPING = 3'd1;
    localparam logic [2:0] CFG_GROW    = 3'd2;
    localparam logic [2:0] CFG_FADE    = 3'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        life_span;
        logic [30:0]        start_size;
        logic [16:0]        base_alpha;
        logic [6:0]         emit_count;
        logic [23:0]        dt;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         slot;
        logic [6:0]         placed;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [30:0]        out_size;
        logic [16:0]        out_alpha;
        logic [6:0]         live_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] gravity_accel;
        logic [30:0]        damping_rate;
        logic signed [31:0] size_grow_rate;
        logic               fade_enable;
    } t_cfg;

    // classified command from the front
    typedef struct packed {
        logic               is_tick;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        life;
        logic [30:0]        size;
        logic [16:0]        alpha;
        logic [6:0]         count;
        logic [23:0]        dt;
    } t_cmd;

    // one slot as held in the slot memory
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [31:0]        age;
        logic [30:0]        life;
        logic [30:0]        size;
        logic [16:0]        alpha;
    } t_slot_word;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppi_ram.sv =====
module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ppi_fifo.sv =====
module ppi_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/ppi_front.sv =====
module ppi_front
    import ppi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_cmd_pop,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd
);

    t_cmd cmd;
    logic empty;

    // classify the transaction and clamp base alpha to one
    always_comb begin
        cmd.is_tick = i_item.mode;
        cmd.pos_x   = i_item.pos_x;
        cmd.pos_y   = i_item.pos_y;
        cmd.pos_z   = i_item.pos_z;
        cmd.vel_x   = i_item.vel_x;
        cmd.vel_y   = i_item.vel_y;
        cmd.vel_z   = i_item.vel_z;
        cmd.life    = i_item.life_span;
        cmd.size    = i_item.start_size;
        cmd.alpha   = (i_item.base_alpha > ONE_Q16) ? ONE_Q16 : i_item.base_alpha;
        cmd.count   = i_item.emit_count;
        cmd.dt      = i_item.dt;
    end

    ppi_fifo #(.WIDTH($bits(t_cmd))) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (empty)
    );

    assign o_cmd_valid = !empty;

endmodule

// ===== rtl/ppi_div.sv =====
module ppi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    // num < den, so the quotient of num * 2^16 / den has 16 bits
    logic [32:0] r_rem;
    logic [30:0] r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] shifted;
    logic        ge;

    assign shifted = {r_rem[31:0], 1'b0};
    assign ge      = (shifted >= {2'b00, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= 16'd0;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - {2'b00, r_den}) : shifted;
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/ppi_engine.sv =====
module ppi_engine
    import ppi_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_push,
    output t_out_item o_res,
    input  logic      i_res_full
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_EMIT  = 15'b000000000000010,
        S_EREP  = 15'b000000000000100,
        S_TM0   = 15'b000000000001000,
        S_TM1   = 15'b000000000010000,
        S_TM2   = 15'b000000000100000,
        S_TM3   = 15'b000000001000000,
        S_WRD   = 15'b000000010000000,
        S_WAGE  = 15'b000000100000000,
        S_WMUL  = 15'b000001000000000,
        S_WDIV  = 15'b000010000000000,
        S_WWR   = 15'b000100000000000,
        S_RRD   = 15'b001000000000000,
        S_RPUSH = 15'b010000000000000,
        S_NONE  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [SLOT_COUNT-1:0] r_live, n_live;
    logic [IW-1:0]   r_idx, n_idx;
    logic [6:0]      r_placed, n_placed;
    logic [6:0]      r_live_cnt, n_live_cnt;
    logic [6:0]      r_k, n_k;
    logic [2:0]      r_step, n_step;
    logic signed [39:0] r_half, n_half;
    logic signed [31:0] r_damp, n_damp;
    logic signed [40:0] r_grow, n_grow;
    t_slot_word      r_w, n_w;
    logic signed [65:0] r_prod;

    // shared multiplier and memory controls
    logic signed [32:0] mul_a, mul_b;
    logic               ram_we, ram_re;
    t_slot_word         ram_wdata, ram_rdata, emit_word;
    logic               div_start, div_done;
    logic [15:0]        div_quot;
    logic signed [32:0] dt_s;
    logic signed [47:0] sh16;
    logic [32:0]        age_sum;
    logic [31:0]        age_sat;
    logic signed [47:0] size_sum;
    logic signed [47:0] damp_full;

    assign dt_s = {9'd0, r_cmd.dt};
    assign sh16 = r_prod[63:16];

    always_comb begin
        emit_word.px    = r_cmd.pos_x;
        emit_word.py    = r_cmd.pos_y;
        emit_word.pz    = r_cmd.pos_z;
        emit_word.vx    = r_cmd.vel_x;
        emit_word.vy    = r_cmd.vel_y;
        emit_word.vz    = r_cmd.vel_z;
        emit_word.age   = 32'd0;
        emit_word.life  = r_cmd.life;
        emit_word.size  = r_cmd.size;
        emit_word.alpha = r_cmd.alpha;
    end

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TM0: begin
                mul_a = {i_cfg.gravity_accel[31], i_cfg.gravity_accel};
                mul_b = dt_s;
            end
            S_TM1: begin
                mul_a = {2'b00, i_cfg.damping_rate};
                mul_b = dt_s;
            end
            S_TM2: begin
                mul_a = {i_cfg.size_grow_rate[31], i_cfg.size_grow_rate};
                mul_b = dt_s;
            end
            S_WMUL: begin
                case (r_step)
                    3'd0: begin
                        mul_a = {r_w.vx[31], r_w.vx};
                        mul_b = {r_damp[31], r_damp};
                    end
                    3'd1: begin
                        mul_a = {r_w.vy[31], r_w.vy};
                        mul_b = {r_damp[31], r_damp};
                    end
                    3'd2: begin
                        mul_a = {r_w.vz[31], r_w.vz};
                        mul_b = {r_damp[31], r_damp};
                    end
                    3'd3: begin
                        mul_a = {r_w.vx[31], r_w.vx};
                        mul_b = dt_s;
                    end
                    3'd4: begin
                        mul_a = {r_w.vy[31], r_w.vy};
                        mul_b = dt_s;
                    end
                    3'd5: begin
                        mul_a = {r_w.vz[31], r_w.vz};
                        mul_b = dt_s;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // helper arithmetic
    assign age_sum   = {1'b0, ram_rdata.age} + {9'd0, r_cmd.dt};
    assign age_sat   = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
    assign size_sum  = $signed({17'd0, r_w.size}) + 48'(r_grow);
    assign damp_full = 48'sd65536 - 48'(r_prod[56:16]);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_live     = r_live;
        n_idx      = r_idx;
        n_placed   = r_placed;
        n_live_cnt = r_live_cnt;
        n_k        = r_k;
        n_step     = r_step;
        n_half     = r_half;
        n_damp     = r_damp;
        n_grow     = r_grow;
        n_w        = r_w;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = r_w;
        div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_placed  = 7'd0;
                    n_state   = i_cmd.is_tick ? S_TM0 : S_EMIT;
                end
            end
            // fill the lowest free slots
            S_EMIT: begin
                if (r_placed == r_cmd.count) begin
                    n_state = S_EREP;
                end else begin
                    if (!r_live[r_idx]) begin
                        ram_we        = 1'b1;
                        ram_wdata     = emit_word;
                        n_live[r_idx] = 1'b1;
                        n_live_cnt    = r_live_cnt + 7'd1;
                        n_placed      = r_placed + 7'd1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_EREP;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_EREP: begin
                o_res.kind       = KIND_EMIT;
                o_res.placed     = r_placed;
                o_res.live_count = r_live_cnt;
                o_res.last       = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            // per-tick terms
            S_TM0: begin
                n_state = S_TM1;
            end
            S_TM1: begin
                n_half  = r_prod[56:17];
                n_state = S_TM2;
            end
            S_TM2: begin
                n_damp  = (i_cfg.damping_rate == 31'd0) ? 32'sd65536 : sat32(damp_full);
                n_state = S_TM3;
            end
            S_TM3: begin
                n_grow  = r_prod[56:16];
                n_idx   = '0;
                n_state = S_WRD;
            end
            // integration walk
            S_WRD: begin
                if (r_live[r_idx]) begin
                    ram_re  = 1'b1;
                    n_state = S_WAGE;
                end else if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_k     = 7'd0;
                    n_state = (r_live_cnt == 7'd0) ? S_NONE : S_RRD;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_WAGE: begin
                if (age_sat >= {1'b0, ram_rdata.life}) begin
                    n_live[r_idx] = 1'b0;
                    n_live_cnt    = r_live_cnt - 7'd1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_k     = 7'd0;
                        n_state = (n_live_cnt == 7'd0) ? S_NONE : S_RRD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_WRD;
                    end
                end else begin
                    n_w     = ram_rdata;
                    n_w.age = age_sat;
                    n_w.vy  = sat32(48'(ram_rdata.vy) - 48'(r_half));
                    n_step  = 3'd0;
                    n_state = S_WMUL;
                end
            end
            // damping then drift, one product per cycle
            S_WMUL: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd1: n_w.vx = sat32(sh16);
                    3'd2: n_w.vy = sat32(sh16);
                    3'd3: n_w.vz = sat32(sh16);
                    3'd4: n_w.px = sat32(48'(r_w.px) + sh16);
                    3'd5: n_w.py = sat32(48'(r_w.py) + sh16);
                    3'd6: begin
                        n_w.pz = sat32(48'(r_w.pz) + sh16);
                        n_w.vy = sat32(48'(r_w.vy) - 48'(r_half));
                        if (size_sum < 48'sd0) begin
                            n_w.size = 31'd0;
                        end else if (size_sum > 48'sd2147483647) begin
                            n_w.size = 31'h7FFFFFFF;
                        end else begin
                            n_w.size = size_sum[30:0];
                        end
                        if (i_cfg.fade_enable) begin
                            div_start = 1'b1;
                            n_state   = S_WDIV;
                        end else begin
                            n_state = S_WWR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WDIV: begin
                if (div_done) begin
                    n_w.alpha = ONE_Q16 - {1'b0, div_quot};
                    n_state   = S_WWR;
                end
            end
            S_WWR: begin
                ram_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_k     = 7'd0;
                    n_state = (r_live_cnt == 7'd0) ? S_NONE : S_RRD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_WRD;
                end
            end
            // report survivors in slot order
            S_RRD: begin
                if (r_live[r_idx]) begin
                    ram_re  = 1'b1;
                    n_state = S_RPUSH;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_RPUSH: begin
                o_res.kind       = KIND_PART;
                o_res.slot       = 6'(r_idx);
                o_res.out_x      = ram_rdata.px;
                o_res.out_y      = ram_rdata.py;
                o_res.out_z      = ram_rdata.pz;
                o_res.out_size   = ram_rdata.size;
                o_res.out_alpha  = ram_rdata.alpha;
                o_res.live_count = r_live_cnt;
                o_res.last       = (r_k == r_live_cnt - 7'd1);
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (o_res.last || r_idx == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 7'd1;
                        n_idx   = r_idx + IW'(1);
                        n_state = S_RRD;
                    end
                end
            end
            S_NONE: begin
                o_res.kind = KIND_NONE;
                o_res.last = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_live     <= '0;
            r_live_cnt <= 7'd0;
        end else begin
            r_state    <= n_state;
            r_live     <= n_live;
            r_live_cnt <= n_live_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_placed <= n_placed;
        r_k      <= n_k;
        r_step   <= n_step;
        r_half   <= n_half;
        r_damp   <= n_damp;
        r_grow   <= n_grow;
        r_w      <= n_w;
    end

    ppi_ram #(
        .WIDTH ($bits(t_slot_word)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    ppi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_w.age),
        .i_den   (r_w.life),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

// ===== rtl/particle_pool_integrator_core.sv =====
// Particle pool of SLOT_COUNT slots with Q16.16 leapfrog integration. Push an emit
// transaction (mode 0) to fill the lowest free slots, or a tick (mode 1) to age, kick,
// damp and drift every live slot; results come out of a queue, one emit report, one
// report per survivor in slot order, or a single no-survivor record, with last set on
// the final one. A tick walks every slot; each survivor passes through the shared 33x33
// multiplier steps and, with fading on, the bit-serial alpha divider, and survivors are
// then reported by reading them back through the single read port of the slot memory.
// A full result queue stalls the block.
// Write the configuration registers only while the block is idle.
`include "particle_pool_integrator_core_macros.svh"

module particle_pool_integrator_core
    import ppi_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_pop;
    logic      res_push;
    t_out_item res;
    logic      res_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_accel  <= 32'sd0;
            r_cfg.damping_rate   <= 31'd0;
            r_cfg.size_grow_rate <= 32'sd0;
            r_cfg.fade_enable    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRAVITY: r_cfg.gravity_accel  <= i_cfg_data;
                CFG_DAMPING: r_cfg.damping_rate   <= i_cfg_data[30:0];
                CFG_GROW:    r_cfg.size_grow_rate <= i_cfg_data;
                CFG_FADE:    r_cfg.fade_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ppi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    ppi_engine #(.SLOT_COUNT(SLOT_COUNT)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // result queue
    ppi_fifo #(.WIDTH($bits(t_out_item))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    // checks
    `PPI_ASSERT_NOW(a_res_no_overflow, i_clk, i_rst_n, res_push, !res_full, "result pushed into full queue")
    `PPI_ASSERT_NOW(a_cmd_pop_valid, i_clk, i_rst_n, cmd_pop, cmd_valid, "command popped from empty queue")
    `PPI_ASSERT_NOW(a_none_is_last, i_clk, i_rst_n, !empty && o_result.kind == KIND_NONE, o_result.last && o_result.live_count == 7'd0, "no-survivor record malformed")
    `PPI_ASSERT_NEXT(a_pop_hold_cmd, i_clk, i_rst_n, cmd_pop, !cmd_pop, "two commands taken back to back")

endmodule

// ===== bench/particle_pool_checker.sv =====
`timescale 1ns / 1ps

// watches the queue ports and the register port, predicts and compares
module particle_pool_checker
    import ppi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  t_in_item    i_item,
    input  logic        pop,
    input  logic        empty,
    input  t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_emits,
    output int          o_ticks
);

    localparam int NSLOT = 64;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // predicted pool and register state
    t_cfg               regs;
    bit                 alive     [NSLOT];
    logic signed [31:0] pos       [NSLOT][3];
    logic signed [31:0] vel       [NSLOT][3];
    logic [31:0]        age       [NSLOT];
    logic [30:0]        life      [NSLOT];
    logic [30:0]        psize     [NSLOT];
    logic [16:0]        palpha    [NSLOT];
    t_out_item          expected_q[$];

    assign o_pending = expected_q.size();

    function automatic longint clamp32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic int count_alive();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) n += alive[i];
        return n;
    endfunction

    // fill lowest free slots, one emit report
    task automatic model_emit(input t_in_item it);
        t_out_item r;
        int        placed;
        logic [16:0] a;
        placed = 0;
        a = (it.base_alpha > ONE_Q16) ? ONE_Q16 : it.base_alpha;
        for (int i = 0; i < NSLOT; i++) begin
            if (placed >= it.emit_count) break;
            if (alive[i]) continue;
            pos[i][0] = it.pos_x; pos[i][1] = it.pos_y; pos[i][2] = it.pos_z;
            vel[i][0] = it.vel_x; vel[i][1] = it.vel_y; vel[i][2] = it.vel_z;
            age[i]    = '0;
            life[i]   = it.life_span;
            psize[i]  = it.start_size;
            palpha[i] = a;
            alive[i]  = 1'b1;
            placed++;
        end
        r = '0;
        r.kind       = KIND_EMIT;
        r.placed     = placed[6:0];
        r.live_count = 7'(count_alive());
        r.last       = 1'b1;
        expected_q.push_back(r);
    endtask

    // age, kick, damp, drift, kick, grow, fade; then report survivors or a no-survivor record
    task automatic model_tick(input t_in_item it);
        longint    dtl, half, damp, grow, a, s, ratio;
        t_out_item r;
        int        live, k;
        dtl  = longint'(it.dt);
        half = (longint'(regs.gravity_accel) * dtl) >>> 17;
        damp = 65536;
        if (regs.damping_rate != 0)
            damp = clamp32(65536 - ((longint'(regs.damping_rate) * dtl) >>> 16));
        grow = (longint'(regs.size_grow_rate) * dtl) >>> 16;
        for (int i = 0; i < NSLOT; i++) begin
            if (!alive[i]) continue;
            a = longint'(age[i]) + dtl;
            if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
            age[i] = a[31:0];
            if (age[i] >= {1'b0, life[i]}) begin
                alive[i] = 1'b0;
                continue;
            end
            vel[i][1] = 32'(clamp32(longint'(vel[i][1]) - half));
            for (int d = 0; d < 3; d++)
                vel[i][d] = 32'(clamp32((longint'(vel[i][d]) * damp) >>> 16));
            for (int d = 0; d < 3; d++)
                pos[i][d] = 32'(clamp32(longint'(pos[i][d])
                                        + ((longint'(vel[i][d]) * dtl) >>> 16)));
            vel[i][1] = 32'(clamp32(longint'(vel[i][1]) - half));
            s = longint'(psize[i]) + grow;
            if (s < 0) s = 0;
            if (s > S32_MAX) s = S32_MAX;
            psize[i] = s[30:0];
            if (regs.fade_enable) begin
                ratio     = (longint'(age[i]) << 16) / longint'(life[i]);
                palpha[i] = 17'(65536 - ratio);
            end
        end
        live = count_alive();
        k = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!alive[i]) continue;
            r = '0;
            r.kind       = KIND_PART;
            r.slot       = i[5:0];
            r.out_x      = pos[i][0];
            r.out_y      = pos[i][1];
            r.out_z      = pos[i][2];
            r.out_size   = psize[i];
            r.out_alpha  = palpha[i];
            r.live_count = live[6:0];
            r.last       = (k == live - 1);
            expected_q.push_back(r);
            k++;
        end
        if (k == 0) begin
            r = '0;
            r.kind = KIND_NONE;
            r.last = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v, inout bit bad);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            bad = 1'b1;
        end
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        bit        bad;
        bad = 1'b0;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, got %p", $time, got);
            o_errors++;
            return;
        end
        want = expected_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind), bad);
        check_field("slot", 32'(want.slot), 32'(got.slot), bad);
        check_field("placed", 32'(want.placed), 32'(got.placed), bad);
        check_field("out_x", want.out_x, got.out_x, bad);
        check_field("out_y", want.out_y, got.out_y, bad);
        check_field("out_z", want.out_z, got.out_z, bad);
        check_field("out_size", 32'(want.out_size), 32'(got.out_size), bad);
        check_field("out_alpha", 32'(want.out_alpha), 32'(got.out_alpha), bad);
        check_field("live_count", 32'(want.live_count), 32'(got.live_count), bad);
        check_field("last", 32'(want.last), 32'(got.last), bad);
        if (bad) o_errors++;
    endtask

    // sample every handshake at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.gravity_accel  = '0;
            regs.damping_rate   = '0;
            regs.size_grow_rate = '0;
            regs.fade_enable    = 1'b1;
            for (int i = 0; i < NSLOT; i++) alive[i] = 1'b0;
            expected_q.delete();
            o_errors  = 0;
            o_results = 0;
            o_emits   = 0;
            o_ticks   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRAVITY: regs.gravity_accel  = i_cfg_data;
                    CFG_DAMPING: regs.damping_rate   = i_cfg_data[30:0];
                    CFG_GROW:    regs.size_grow_rate = i_cfg_data;
                    CFG_FADE:    regs.fade_enable    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                compare_result(o_result);
                o_results++;
            end
            if (push && !full) begin
                if (i_item.mode) begin
                    model_tick(i_item);
                    o_ticks++;
                end else begin
                    model_emit(i_item);
                    o_emits++;
                end
            end
        end
    end

endmodule

// ===== bench/tb_particle_pool_integrator_core.sv =====
`timescale 1ns / 1ps

module tb_particle_pool_integrator_core;
    import ppi_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam logic       MODE_EMIT  = 1'b0;
    localparam logic       MODE_TICK  = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        pop = 1'b0;
    logic        empty;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int errors, pending, results, emits, ticks;
    int tx_idle, rx_idle;
    bit hold_rx;

    particle_pool_integrator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    particle_pool_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_emits    (emits),
        .o_ticks    (ticks)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random pop, forced low during a long hold-off
    always @(posedge i_clk) begin
        pop <= !hold_rx && ($urandom_range(0, 99) >= rx_idle);
    end

    // run limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // word biased toward the signed extremes and small values near zero
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_fields();
        t_in_item it;
        it.mode       = 1'($urandom_range(0, 1));
        it.pos_x      = pick_word();
        it.pos_y      = pick_word();
        it.pos_z      = pick_word();
        it.vel_x      = pick_word();
        it.vel_y      = pick_word();
        it.vel_z      = pick_word();
        it.life_span  = 31'($urandom);
        it.start_size = 31'($urandom);
        it.base_alpha = 17'($urandom);
        it.emit_count = 7'($urandom_range(0, 64));
        it.dt         = 24'($urandom);
        return it;
    endfunction

    // emit with mostly moderate lifetimes so the pool stays populated
    function automatic t_in_item rand_emit();
        t_in_item it;
        it = rand_fields();
        it.mode = MODE_EMIT;
        if ($urandom_range(0, 9) != 0) it.life_span = 31'($urandom_range(0, 20 * 65536));
        if ($urandom_range(0, 3) != 0) it.emit_count = 7'($urandom_range(1, 12));
        if ($urandom_range(0, 3) != 0) it.base_alpha = 17'($urandom_range(0, 65536));
        return it;
    endfunction

    // tick with mostly short steps
    function automatic t_in_item rand_tick();
        t_in_item it;
        it = rand_fields();
        it.mode = MODE_TICK;
        if ($urandom_range(0, 9) != 0) it.dt = 24'($urandom_range(0, 16384));
        return it;
    endfunction

    task automatic send(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        push       <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // sender pauses until every expected transaction has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic rx_hold_off(input int cycles);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
    endtask

    task automatic random_items(input int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 40) send(rand_emit());
            else send(rand_tick());
        end
    endtask

    initial begin
        t_in_item it;
        int       settle;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        hold_rx    = 1'b0;
        tx_idle    = 0;
        rx_idle    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pool, zero count, zero life, saturating alpha, full pool
        it = rand_tick();  it.dt = 24'd5;                           send(it);
        it = rand_emit();  it.emit_count = 7'd0;                    send(it);
        it = rand_emit();  it.emit_count = 7'd3; it.life_span = 31'd0;
        it.base_alpha = 17'h1FFFF; it.pos_x = 32'h7FFF_FFFF;        send(it);
        it = rand_emit();  it.emit_count = 7'd64; it.life_span = 31'h7FFF_FFFF;
        it.start_size = 31'h7FFF_FFFF; it.base_alpha = 17'd65536;
        it.pos_y = 32'h8000_0000; it.vel_x = 32'h7FFF_FFFF;
        it.vel_y = 32'h8000_0000;                                   send(it);
        it = rand_emit();  it.emit_count = 7'd5;                    send(it);
        it = rand_tick();  it.dt = 24'd0;                           send(it);
        it = rand_emit();  it.emit_count = 7'd2; it.life_span = 31'd1; send(it);
        it = rand_tick();  it.dt = 24'hFF_FFFF;                     send(it);
        drain();

        // register extremes, an out-of-range index, fade off
        cfg_write(CFG_GRAVITY, 32'h7FFF_FFFF);
        cfg_write(CFG_DAMPING, 32'h7FFF_FFFF);
        cfg_write(CFG_GROW, 32'h8000_0000);
        cfg_write(CFG_FADE, 32'd0);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        it = rand_tick();  it.dt = 24'h00_4000;                     send(it);
        it = rand_emit();  it.emit_count = 7'd4; it.life_span = 31'd655360;
        it.base_alpha = 17'd40000;                                  send(it);
        it = rand_tick();  it.dt = 24'h00_0100;                     send(it);
        drain();

        cfg_write(CFG_GRAVITY, 32'h8000_0000);
        cfg_write(CFG_DAMPING, 32'd1);
        cfg_write(CFG_GROW, 32'h7FFF_FFFF);
        cfg_write(CFG_FADE, 32'd1);
        it = rand_tick();  it.dt = 24'h00_8000;                     send(it);
        it = rand_emit();  it.emit_count = 7'd6;                    send(it);
        it = rand_tick();  it.dt = 24'hFF_FFFF;                     send(it);
        it = rand_tick();  it.dt = 24'hFF_FFFF;                     send(it);
        drain();

        // random, sender idles less than receiver
        cfg_write(CFG_GRAVITY, 32'd642252);
        cfg_write(CFG_DAMPING, 32'd32768);
        cfg_write(CFG_GROW, 32'hFFFF_0000);
        tx_idle = 27;
        rx_idle = 65;
        random_items(85);
        drain();

        // random, receiver idles less than sender
        cfg_write(CFG_GRAVITY, $urandom);
        cfg_write(CFG_DAMPING, $urandom_range(0, 32'h0008_0000));
        cfg_write(CFG_GROW, $urandom);
        cfg_write(CFG_FADE, 32'd0);
        tx_idle = 65;
        rx_idle = 27;
        random_items(80);
        drain();

        // random, no idling, with a long receiver hold-off to back up the input
        cfg_write(CFG_GRAVITY, 32'hFFF6_3334);
        cfg_write(CFG_DAMPING, 32'd0);
        cfg_write(CFG_GROW, 32'd6554);
        cfg_write(CFG_FADE, 32'd1);
        tx_idle = 0;
        rx_idle = 0;
        rx_hold_off(3000);
        random_items(85);
        push <= 1'b0;

        // wait for outstanding results, then let the block settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        settle = 0;
        while (settle < 3000) begin
            @(posedge i_clk);
            settle++;
        end

        $display("covered %0d emit and %0d tick transactions, %0d results checked",
                 emits, ticks, results);
        $display("register extremes, fade on and off, full pool and zero-life slots exercised");
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
